### rtl/info_frame_byte_stuffing_framer_unit_defines.svh
// Assertion macros for the information frame byte stuffing framer.
// Depends on nothing; the asserting file supplies clk_i and rst_ni.
`ifndef INFO_FRAME_BYTE_STUFFING_FRAMER_UNIT_DEFINES_SVH
`define INFO_FRAME_BYTE_STUFFING_FRAMER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFBSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFBSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ifbsf_pkg.sv
// Shared types, constants and helpers of the information frame framer.
// Used by every module of the block; depends on nothing.
package ifbsf_pkg;

  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] CfgFlag      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgAddress   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgEscape    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgEscFlag   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgEscEscape = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgCtrlZero  = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CfgCtrlOne   = 3'd6;

  localparam logic [7:0] RstFlag      = 8'd126;
  localparam logic [7:0] RstAddress   = 8'd3;
  localparam logic [7:0] RstEscape    = 8'd125;
  localparam logic [7:0] RstEscFlag   = 8'd94;
  localparam logic [7:0] RstEscEscape = 8'd93;
  localparam logic [7:0] RstCtrlZero  = 8'd0;
  localparam logic [7:0] RstCtrlOne   = 8'd64;

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_FLAG,
    CLS_ESC
  } byte_cls_e;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] addr;
    logic [7:0] esc;
    logic [7:0] esc_flag;
    logic [7:0] esc_esc;
    logic [7:0] ctrl0;
    logic [7:0] ctrl1;
  } cfg_t;

  typedef struct packed {
    logic       hdr;
    logic       seq;
    logic [7:0] data;
    byte_cls_e  data_cls;
    logic       last;
    logic [7:0] chk;
    byte_cls_e  chk_cls;
  } desc_t;

  // A byte equal to both flag and escape counts as a flag.
  function automatic byte_cls_e classify(logic [7:0] b, cfg_t cfg);
    byte_cls_e cls;
    if (b == cfg.flag) begin
      cls = CLS_FLAG;
    end else if (b == cfg.esc) begin
      cls = CLS_ESC;
    end else begin
      cls = CLS_PLAIN;
    end
    return cls;
  endfunction

endpackage

### rtl/ifbsf_front.sv
// Front end: accepts payload bytes, tracks the open frame and its check byte,
// and classifies each request into a descriptor. Depends on ifbsf_pkg.
module ifbsf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ifbsf_pkg::cfg_t   cfg_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [7:0]        payload_byte_i,
  input  logic              sequence_bit_i,
  input  logic              last_payload_i,
  output logic              wr_o,
  output ifbsf_pkg::desc_t  desc_o
);

  logic       inside_q, inside_d;
  logic [7:0] check_q, check_d;
  logic [7:0] new_chk;

  assign wr_o    = push_i & ~full_i;
  assign new_chk = inside_q ? (check_q ^ payload_byte_i) : payload_byte_i;

  always_comb begin
    desc_o.hdr      = ~inside_q;
    desc_o.seq      = sequence_bit_i;
    desc_o.data     = payload_byte_i;
    desc_o.data_cls = ifbsf_pkg::classify(payload_byte_i, cfg_i);
    desc_o.last     = last_payload_i;
    desc_o.chk      = new_chk;
    desc_o.chk_cls  = ifbsf_pkg::classify(new_chk, cfg_i);
  end

  always_comb begin
    inside_d = inside_q;
    check_d  = check_q;
    if (wr_o) begin
      inside_d = ~last_payload_i;
      check_d  = last_payload_i ? 8'd0 : new_chk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      check_q  <= 8'd0;
    end else begin
      inside_q <= inside_d;
      check_q  <= check_d;
    end
  end

endmodule

### rtl/ifbsf_queue.sv
// Small descriptor queue between the front end and the back end.
// Depends on ifbsf_pkg for the descriptor type.
module ifbsf_queue #(
  parameter int unsigned Depth = ifbsf_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  ifbsf_pkg::desc_t  wdata_i,
  input  logic              rd_i,
  output ifbsf_pkg::desc_t  rdata_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ifbsf_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/ifbsf_back.sv
// Back end: walks each descriptor through the header (when it opens a frame), stuffed
// data and, for the last byte, check and closing flag, one line byte per cycle into the
// output register while it is empty or being popped. Depends on ifbsf_pkg.
module ifbsf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ifbsf_pkg::cfg_t   cfg_i,
  input  ifbsf_pkg::desc_t  desc_i,
  input  logic              desc_valid_i,
  output logic              deq_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        line_byte_o,
  output logic              run_last_o,
  output logic              frame_end_o
);

  localparam logic [3:0] StStart = 4'd0;
  localparam logic [3:0] StFlag  = 4'd1;
  localparam logic [3:0] StAddr  = 4'd2;
  localparam logic [3:0] StCtrl  = 4'd3;
  localparam logic [3:0] StHcs   = 4'd4;
  localparam logic [3:0] StD0    = 4'd5;
  localparam logic [3:0] StD1    = 4'd6;
  localparam logic [3:0] StC0    = 4'd7;
  localparam logic [3:0] StC1    = 4'd8;
  localparam logic [3:0] StClose = 4'd9;

  logic [3:0] step_q, step_d, cur, nxt;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d, ctrl, out_byte;
  logic       last_q, last_d;
  logic       fend_q, fend_d;
  logic       fend, done, adv, out_ready;

  assign out_ready = ~valid_q | pop_i;
  assign adv       = desc_valid_i & out_ready;
  assign cur       = (step_q == StStart) ? (desc_i.hdr ? StFlag : StD0) : step_q;
  assign ctrl      = desc_i.seq ? cfg_i.ctrl1 : cfg_i.ctrl0;
  assign done      = (nxt == StStart);
  assign deq_o     = adv & done;

  always_comb begin
    out_byte = cfg_i.flag;
    fend     = 1'b0;
    nxt      = StStart;
    case (cur)
      StFlag: begin
        out_byte = cfg_i.flag;
        nxt      = StAddr;
      end
      StAddr: begin
        out_byte = cfg_i.addr;
        nxt      = StCtrl;
      end
      StCtrl: begin
        out_byte = ctrl;
        nxt      = StHcs;
      end
      StHcs: begin
        out_byte = cfg_i.addr ^ ctrl;
        nxt      = StD0;
      end
      StD0: begin
        if (desc_i.data_cls == ifbsf_pkg::CLS_PLAIN) begin
          out_byte = desc_i.data;
          nxt      = desc_i.last ? StC0 : StStart;
        end else begin
          out_byte = cfg_i.esc;
          nxt      = StD1;
        end
      end
      StD1: begin
        out_byte = (desc_i.data_cls == ifbsf_pkg::CLS_FLAG) ? cfg_i.esc_flag
                                                            : cfg_i.esc_esc;
        nxt      = desc_i.last ? StC0 : StStart;
      end
      StC0: begin
        if (desc_i.chk_cls == ifbsf_pkg::CLS_PLAIN) begin
          out_byte = desc_i.chk;
          nxt      = StClose;
        end else begin
          out_byte = cfg_i.esc;
          nxt      = StC1;
        end
      end
      StC1: begin
        out_byte = (desc_i.chk_cls == ifbsf_pkg::CLS_FLAG) ? cfg_i.esc_flag
                                                           : cfg_i.esc_esc;
        nxt      = StClose;
      end
      StClose: begin
        out_byte = cfg_i.flag;
        fend     = 1'b1;
        nxt      = StStart;
      end
      default: begin
        out_byte = cfg_i.flag;
        nxt      = StStart;
      end
    endcase
  end

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    fend_d  = fend_q;
    if (adv) begin
      step_d  = nxt;
      valid_d = 1'b1;
      byte_d  = out_byte;
      last_d  = done;
      fend_d  = fend;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StStart;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    fend_q <= fend_d;
  end

  assign empty_o     = ~valid_q;
  assign line_byte_o = byte_q;
  assign run_last_o  = last_q;
  assign frame_end_o = fend_q;

endmodule

### rtl/info_frame_byte_stuffing_framer_unit.sv
// Top level of the information frame byte stuffing framer: configuration
// registers, front end, descriptor queue and back end.
// Depends on ifbsf_pkg, ifbsf_front, ifbsf_queue, ifbsf_back and the defines header.
//
//   Channel   Handshake            Payload
//   input     push_i / full_o      payload_byte_i, sequence_bit_i, last_payload_i
//   result    empty_o / pop_i      line_byte_o, run_last_o, frame_end_o
//   config    cfg_we_i             cfg_idx_i, cfg_data_i
//
// The back end sends one line byte per cycle while a descriptor waits and the result
// register is empty or popped, so a request yields 1 to 9 line bytes: one or two for a
// mid-frame byte, four more with the header, up to three more with the check and closing
// flag. The front end takes a request every cycle while the descriptor queue has room,
// so headers and trailers are absorbed. Reset empties the queue and the output register,
// closes any open frame and loads the default register values. A held result stalls the back end, then the input.

`include "info_frame_byte_stuffing_framer_unit_defines.svh"

module info_frame_byte_stuffing_framer_unit #(
  parameter int unsigned QueueDepth = ifbsf_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ifbsf_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [7:0]                        cfg_data_i,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [7:0]                        payload_byte_i,
  input  logic                              sequence_bit_i,
  input  logic                              last_payload_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [7:0]                        line_byte_o,
  output logic                              run_last_o,
  output logic                              frame_end_o
);

  ifbsf_pkg::cfg_t  cfg_q, cfg_d;
  ifbsf_pkg::desc_t wr_desc, rd_desc;
  logic             wr, deq, q_empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ifbsf_pkg::CfgFlag:      cfg_d.flag     = cfg_data_i;
        ifbsf_pkg::CfgAddress:   cfg_d.addr     = cfg_data_i;
        ifbsf_pkg::CfgEscape:    cfg_d.esc      = cfg_data_i;
        ifbsf_pkg::CfgEscFlag:   cfg_d.esc_flag = cfg_data_i;
        ifbsf_pkg::CfgEscEscape: cfg_d.esc_esc  = cfg_data_i;
        ifbsf_pkg::CfgCtrlZero:  cfg_d.ctrl0    = cfg_data_i;
        ifbsf_pkg::CfgCtrlOne:   cfg_d.ctrl1    = cfg_data_i;
        default:                 cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag     <= ifbsf_pkg::RstFlag;
      cfg_q.addr     <= ifbsf_pkg::RstAddress;
      cfg_q.esc      <= ifbsf_pkg::RstEscape;
      cfg_q.esc_flag <= ifbsf_pkg::RstEscFlag;
      cfg_q.esc_esc  <= ifbsf_pkg::RstEscEscape;
      cfg_q.ctrl0    <= ifbsf_pkg::RstCtrlZero;
      cfg_q.ctrl1    <= ifbsf_pkg::RstCtrlOne;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ifbsf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .push_i         (push_i),
    .full_i         (full_o),
    .payload_byte_i (payload_byte_i),
    .sequence_bit_i (sequence_bit_i),
    .last_payload_i (last_payload_i),
    .wr_o           (wr),
    .desc_o         (wr_desc)
  );

  ifbsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .wdata_i (wr_desc),
    .rd_i    (deq),
    .rdata_o (rd_desc),
    .empty_o (q_empty),
    .full_o  (full_o)
  );

  ifbsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .desc_i       (rd_desc),
    .desc_valid_i (~q_empty),
    .deq_o        (deq),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .line_byte_o  (line_byte_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o)
  );

  `IFBSF_ASSERT_NOW(a_deq_has_desc, deq, !q_empty, "descriptor taken from an empty queue")
  `IFBSF_ASSERT_NOW(a_close_is_last, !empty_o && frame_end_o, run_last_o, "closing flag not last")
  `IFBSF_ASSERT_NOW(a_close_is_flag, !empty_o && frame_end_o, line_byte_o == cfg_q.flag,
                    "closing byte differs from the flag")
  `IFBSF_ASSERT_NEXT(a_push_fills, push_i && !full_o && !deq, !q_empty, "request lost in queue")

endmodule

### bench/tb_info_frame_byte_stuffing_framer_unit.sv
// Self-checking testbench of info_frame_byte_stuffing_framer_unit: directed frames, then
// random frames under several register settings, with random idling and back-pressure.
// Depends on ifbsf_pkg and the framer RTL; every line byte is checked against a predictor.
`timescale 1ns / 1ps

module tb_info_frame_byte_stuffing_framer_unit;
  import ifbsf_pkg::*;

  localparam int unsigned ClkPeriod  = 12;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainSlack = 16;
  localparam int unsigned HoldCycles = 400;
  localparam logic [CfgIdxWidth-1:0] CfgUnused = 3'd7;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
  } line_rec_t;

  typedef struct packed {
    logic [7:0] value;
    logic       closing;
  } step_byte_t;

  localparam cfg_t ResetCfg = '{flag: RstFlag, addr: RstAddress, esc: RstEscape,
                                esc_flag: RstEscFlag, esc_esc: RstEscEscape,
                                ctrl0: RstCtrlZero, ctrl1: RstCtrlOne};

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [7:0]             cfg_data_i;
  logic                   push_i;
  logic                   full_o;
  logic [7:0]             payload_byte_i;
  logic                   sequence_bit_i;
  logic                   last_payload_i;
  logic                   empty_o;
  logic                   pop_i;
  logic [7:0]             line_byte_o;
  logic                   run_last_o;
  logic                   frame_end_o;

  cfg_t        line_cfg;
  logic        frame_open;
  logic [7:0]  frame_xor;
  line_rec_t   line_q[$];
  step_byte_t  step_bytes[$];
  line_rec_t   want_line;
  int unsigned errors;
  int unsigned cycles;
  bit          sender_idles;
  bit          receiver_idles;
  bit          hold_req;
  int unsigned hold_left;

  info_frame_byte_stuffing_framer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .payload_byte_i (payload_byte_i),
    .sequence_bit_i (sequence_bit_i),
    .last_payload_i (last_payload_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .line_byte_o    (line_byte_o),
    .run_last_o     (run_last_o),
    .frame_end_o    (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  task automatic add_plain(input logic [7:0] b, input logic closing);
    step_bytes.push_back('{value: b, closing: closing});
  endtask

  task automatic add_stuffed(input logic [7:0] b);
    if (b == line_cfg.flag) begin
      add_plain(line_cfg.esc, 1'b0);
      add_plain(line_cfg.esc_flag, 1'b0);
    end else if (b == line_cfg.esc) begin
      add_plain(line_cfg.esc, 1'b0);
      add_plain(line_cfg.esc_esc, 1'b0);
    end else begin
      add_plain(b, 1'b0);
    end
  endtask

  task automatic frame_encode(input logic [7:0] data, input logic seq, input logic last);
    logic [7:0] ctrl;
    int         n;
    step_bytes.delete();
    if (!frame_open) begin
      ctrl = seq ? line_cfg.ctrl1 : line_cfg.ctrl0;
      add_plain(line_cfg.flag, 1'b0);
      add_plain(line_cfg.addr, 1'b0);
      add_plain(ctrl, 1'b0);
      add_plain(line_cfg.addr ^ ctrl, 1'b0);
      frame_xor = 8'h00;
    end
    add_stuffed(data);
    frame_xor = frame_xor ^ data;
    if (last) begin
      add_stuffed(frame_xor);
      add_plain(line_cfg.flag, 1'b1);
      frame_open = 1'b0;
      frame_xor  = 8'h00;
    end else begin
      frame_open = 1'b1;
    end
    n = step_bytes.size();
    for (int i = 0; i < n; i++) begin
      line_q.push_back('{line_byte: step_bytes[i].value, run_last: (i == n - 1),
                         frame_end: step_bytes[i].closing});
    end
  endtask

  task automatic send_item(input logic [7:0] data, input logic seq, input logic last);
    if (sender_idles) begin
      while ($urandom_range(99) < 20) begin
        @(negedge clk_i);
        push_i         <= 1'b0;
        payload_byte_i <= 8'($urandom);
        sequence_bit_i <= 1'($urandom);
        last_payload_i <= 1'($urandom);
      end
    end
    @(negedge clk_i);
    push_i         <= 1'b1;
    payload_byte_i <= data;
    sequence_bit_i <= seq;
    last_payload_i <= last;
    do @(posedge clk_i); while (full_o !== 1'b0);
    frame_encode(data, seq, last);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (line_q.size() != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgFlag:      line_cfg.flag     = value;
      CfgAddress:   line_cfg.addr     = value;
      CfgEscape:    line_cfg.esc      = value;
      CfgEscFlag:   line_cfg.esc_flag = value;
      CfgEscEscape: line_cfg.esc_esc  = value;
      CfgCtrlZero:  line_cfg.ctrl0    = value;
      CfgCtrlOne:   line_cfg.ctrl1    = value;
      default: ;
    endcase
  endtask

  // The out-of-range index is written too; the block must ignore it.
  task automatic load_config(input cfg_t c);
    stop_sending();
    wait_drain();
    write_reg(CfgFlag, c.flag);
    write_reg(CfgUnused, 8'($urandom));
    write_reg(CfgAddress, c.addr);
    write_reg(CfgEscape, c.esc);
    write_reg(CfgEscFlag, c.esc_flag);
    write_reg(CfgEscEscape, c.esc_esc);
    write_reg(CfgCtrlZero, c.ctrl0);
    write_reg(CfgCtrlOne, c.ctrl1);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= 3'($urandom);
    cfg_data_i <= 8'($urandom);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c = cfg_t'(56'({$urandom, $urandom}));
    if ($urandom_range(99) < 30) c.esc   = c.flag;
    if ($urandom_range(99) < 30) c.addr  = c.flag;
    if ($urandom_range(99) < 30) c.ctrl0 = c.esc;
    if ($urandom_range(99) < 30) c.ctrl1 = c.flag;
    return c;
  endfunction

  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1:    b = line_cfg.flag;
      2, 3:    b = line_cfg.esc;
      4:       b = $urandom_range(1) ? 8'h00 : 8'hff;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // A quarter of the frames end on a byte that makes the check a flag or an escape.
  task automatic send_random_frame(input int unsigned len);
    logic [7:0] data;
    logic [7:0] so_far;
    for (int unsigned i = 0; i < len; i++) begin
      data = pick_payload();
      if (i == len - 1 && $urandom_range(3) == 0) begin
        so_far = frame_open ? frame_xor : 8'h00;
        data   = so_far ^ ($urandom_range(1) ? line_cfg.flag : line_cfg.esc);
      end
      send_item(data, 1'($urandom), i == len - 1);
    end
  endtask

  task automatic test_reset_values();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(RstFlag, 1'b0, 1'b0);
    send_item(RstEscape, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    send_item(RstFlag, 1'b1, 1'b1);
    send_item(RstEscape, 1'b0, 1'b1);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h01 ^ RstFlag, 1'b0, 1'b1);
  endtask

  task automatic test_header_collisions();
    load_config('{flag: 8'h7e, addr: 8'h7e, esc: 8'h7d, esc_flag: 8'h5e, esc_esc: 8'h5d,
                  ctrl0: 8'h7d, ctrl1: 8'h00});
    send_item(8'haa, 1'b0, 1'b0);
    send_item(8'h7d, 1'b1, 1'b1);
    send_item(8'h7e, 1'b1, 1'b1);
  endtask

  task automatic test_flag_equals_escape();
    load_config('{flag: 8'hc3, addr: 8'h0f, esc: 8'hc3, esc_flag: 8'h11, esc_esc: 8'h22,
                  ctrl0: 8'h80, ctrl1: 8'h81});
    send_item(8'hc3, 1'b1, 1'b0);
    send_item(8'h12, 1'b0, 1'b0);
    send_item(8'h12, 1'b1, 1'b1);
  endtask

  task automatic test_config_mid_frame();
    send_item(8'h3c, 1'b0, 1'b0);
    load_config('{flag: 8'h00, addr: 8'hff, esc: 8'hff, esc_flag: 8'h00, esc_esc: 8'hff,
                  ctrl0: 8'hff, ctrl1: 8'h00});
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
  endtask

  task automatic test_back_pressure();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_random_frame($urandom_range(1, 4));
  endtask

  task automatic test_sender_pause();
    send_random_frame(3);
    stop_sending();
    while (line_q.size() != 0) @(posedge clk_i);
    send_random_frame(3);
  endtask

  task automatic test_random_frames();
    cfg_t phase_cfg;
    int unsigned sent;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       phase_cfg = '0;
        1:       phase_cfg = '1;
        2:       phase_cfg = ResetCfg;
        default: phase_cfg = random_cfg();
      endcase
      load_config(phase_cfg);
      sender_idles   = (phase != 3);
      receiver_idles = (phase != 3);
      sent = 0;
      while (sent < 24) begin
        if ($urandom_range(9) == 0) begin
          send_random_frame($urandom_range(8, 14));
          sent += 8;
        end else begin
          send_random_frame($urandom_range(1, 5));
          sent += 3;
        end
      end
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    pop_i     = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else if (receiver_idles) begin
        pop_i <= ($urandom_range(99) >= 20);
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (line_q.size() == 0) begin
        $error("line byte %0h with no request outstanding", line_byte_o);
        errors++;
      end else begin
        want_line = line_q.pop_front();
        if (line_byte_o !== want_line.line_byte) begin
          $error("line_byte: expected %0h, got %0h", want_line.line_byte, line_byte_o);
          errors++;
        end
        if (run_last_o !== want_line.run_last) begin
          $error("run_last: expected %0b, got %0b", want_line.run_last, run_last_o);
          errors++;
        end
        if (frame_end_o !== want_line.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want_line.frame_end, frame_end_o);
          errors++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    push_i         = 1'b0;
    payload_byte_i = '0;
    sequence_bit_i = 1'b0;
    last_payload_i = 1'b0;
    errors         = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_req       = 1'b0;
    line_cfg       = ResetCfg;
    frame_open     = 1'b0;
    frame_xor      = 8'h00;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_header_collisions();
    test_flag_equals_escape();
    test_config_mid_frame();
    test_back_pressure();
    test_sender_pause();
    test_random_frames();

    stop_sending();
    wait_drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
